// ----- rtl/core/voice_steal_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// Voice steal allocator assertion macros
// Concurrent checks sampled on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef VOICE_STEAL_ALLOCATOR_DEFINES_SVH
`define VOICE_STEAL_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define VSA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("voice steal allocator check failed");

// next-cycle implication
`define VSA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("voice steal allocator check failed");

`endif

// ----- rtl/core/vsa_pkg.sv -----
// ----------------------------------------------------------------------------
// Voice steal allocator package
// Field widths, operation codes, register map and the track store control word.
// ----------------------------------------------------------------------------
`default_nettype none

package vsa_pkg;

  localparam int NUM_VOICES_DEF = 24;
  localparam int NUM_TRACKS_DEF = 32;

  localparam int MODE_W  = 3;
  localparam int VOICE_W = 5;
  localparam int TRACK_W = 5;
  localparam int PRIO_W  = 16;
  localparam int MASK_W  = 32;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic signed [PRIO_W-1:0] PRIO_NONE = 16'sh7FFF;

  localparam logic [MODE_W-1:0] MODE_WR_PRIO  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WR_TRACK = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STEAL    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RELEASE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CHECK    = 3'd4;

  localparam logic REG_AUX_EN = 1'b0;

  typedef struct packed {
    logic               wr_en;
    logic               wr_bank;
    logic [TRACK_W-1:0] wr_idx;
    logic [VOICE_W-1:0] wr_val;
    logic [TRACK_W-1:0] rd_idx;
    logic               rd_bank;
    logic               rel_en;
    logic               rel_aux;
    logic [VOICE_W-1:0] rel_voice;
  } trk_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/vsa_track_store.sv -----
// ----------------------------------------------------------------------------
// Voice steal allocator track store
// Main and auxiliary track-to-voice banks with one write port, one swept read
// port and an in-place release of the swept entry.
// ----------------------------------------------------------------------------
`default_nettype none

module vsa_track_store #(
  parameter int NUM_VOICES = vsa_pkg::NUM_VOICES_DEF,
  parameter int NUM_TRACKS = vsa_pkg::NUM_TRACKS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  vsa_pkg::trk_ctrl_t           ctrl_i,
  output logic [vsa_pkg::VOICE_W-1:0]  rd_voice_o
);
  import vsa_pkg::*;

  localparam int TIDX_W = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
  localparam logic [VOICE_W-1:0] VOICE_FREE = VOICE_W'(NUM_VOICES);

  logic [VOICE_W-1:0] main_q [NUM_TRACKS];
  logic [VOICE_W-1:0] aux_q  [NUM_TRACKS];
  logic [TIDX_W-1:0]  ri;
  logic [TIDX_W-1:0]  wi;

  assign ri = ctrl_i.rd_idx[TIDX_W-1:0];
  assign wi = ctrl_i.wr_idx[TIDX_W-1:0];

  assign rd_voice_o = ctrl_i.rd_bank ? aux_q[ri] : main_q[ri];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TRACKS; i++) begin
        main_q[i] <= VOICE_FREE;
        aux_q[i]  <= VOICE_FREE;
      end
    end else begin
      if (ctrl_i.rel_en) begin
        if (main_q[ri] == ctrl_i.rel_voice) begin
          main_q[ri] <= VOICE_FREE;
        end
        if (ctrl_i.rel_aux && aux_q[ri] == ctrl_i.rel_voice) begin
          aux_q[ri] <= VOICE_FREE;
        end
      end
      if (ctrl_i.wr_en) begin
        if (ctrl_i.wr_bank) begin
          aux_q[wi] <= ctrl_i.wr_val;
        end else begin
          main_q[wi] <= ctrl_i.wr_val;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/voice_steal_allocator.sv -----
// ----------------------------------------------------------------------------
// Voice steal allocator
// Priority writes, track writes and unused modes go straight to the result word after accept.
// Release and check sweep every track; steal scans every voice, then releases the chosen
// voice from the tracks when one is taken. One compare a cycle, one item at a time.
// Reset (async, active low): priorities to 0x7FFF, all tracks free, aux enable 0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "voice_steal_allocator_defines.svh"

module voice_steal_allocator #(
  parameter int NUM_VOICES = vsa_pkg::NUM_VOICES_DEF,
  parameter int NUM_TRACKS = vsa_pkg::NUM_TRACKS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vsa_pkg::ADDR_W-1:0]         paddr,
  input  logic [vsa_pkg::DATA_W-1:0]         pwdata,
  output logic [vsa_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [vsa_pkg::MODE_W-1:0]         mode_i,
  input  logic [vsa_pkg::VOICE_W-1:0]        voice_index_i,
  input  logic [vsa_pkg::TRACK_W-1:0]        track_index_i,
  input  logic                               bank_i,
  input  logic signed [vsa_pkg::PRIO_W-1:0]  priority_req_i,
  input  logic [vsa_pkg::MASK_W-1:0]         track_mask_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [vsa_pkg::VOICE_W-1:0]        chosen_voice_o,
  output logic                               hit_o
);
  import vsa_pkg::*;

  localparam int VIDX_W = $clog2(NUM_VOICES);
  localparam int TIDX_W = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
  localparam int CNT_W  = (VIDX_W > TIDX_W) ? VIDX_W : TIDX_W;
  localparam logic [VOICE_W-1:0] VOICE_FREE = VOICE_W'(NUM_VOICES);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_REL  = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]               state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     aux_en_q;
  logic                     out_valid_q, out_valid_d;
  logic [VOICE_W-1:0]       out_voice_q, out_voice_d;
  logic                     out_hit_q, out_hit_d;
  logic [VOICE_W-1:0]       req_voice_q, req_voice_d;
  logic                     req_bank_q, req_bank_d;
  logic [MASK_W-1:0]        req_mask_q, req_mask_d;
  logic signed [PRIO_W-1:0] best_q, best_d;
  logic [VOICE_W-1:0]       best_idx_q, best_idx_d;
  logic [VOICE_W-1:0]       res_voice_q, res_voice_d;
  logic                     res_hit_q, res_hit_d;

  logic signed [PRIO_W-1:0] prio_q [NUM_VOICES];

  logic                     in_acc;
  logic                     scan_last;
  logic                     trk_last;
  logic signed [PRIO_W-1:0] cur_prio;
  logic                     cur_lt;
  logic signed [PRIO_W-1:0] fin_best;
  logic [VOICE_W-1:0]       fin_idx;
  logic [VOICE_W-1:0]       rd_voice;
  trk_ctrl_t                trk_ctrl;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign scan_last  = (cnt_q == CNT_W'(NUM_VOICES - 1));
  assign trk_last   = (cnt_q == CNT_W'(NUM_TRACKS - 1));
  assign cur_prio   = prio_q[cnt_q[VIDX_W-1:0]];
  assign cur_lt     = (cur_prio < best_q);
  assign fin_best   = cur_lt ? cur_prio : best_q;
  assign fin_idx    = cur_lt ? VOICE_W'(cnt_q) : best_idx_q;

  assign pready         = 1'b1;
  assign prdata         = (paddr[2] == REG_AUX_EN) ? {{(DATA_W-1){1'b0}}, aux_en_q} : '0;
  assign out_valid_o    = out_valid_q;
  assign chosen_voice_o = out_voice_q;
  assign hit_o          = out_hit_q;

  always_comb begin
    trk_ctrl.wr_en     = in_acc && (mode_i == MODE_WR_TRACK) &&
                         ({1'b0, track_index_i} < (TRACK_W+1)'(NUM_TRACKS));
    trk_ctrl.wr_bank   = bank_i;
    trk_ctrl.wr_idx    = track_index_i;
    trk_ctrl.wr_val    = (voice_index_i > VOICE_FREE) ? VOICE_FREE : voice_index_i;
    trk_ctrl.rd_idx    = TRACK_W'(cnt_q);
    trk_ctrl.rd_bank   = req_bank_q;
    trk_ctrl.rel_en    = (state_q == ST_REL);
    trk_ctrl.rel_aux   = aux_en_q;
    trk_ctrl.rel_voice = req_voice_q;
  end

  vsa_track_store #(
    .NUM_VOICES (NUM_VOICES),
    .NUM_TRACKS (NUM_TRACKS)
  ) u_track_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (trk_ctrl),
    .rd_voice_o (rd_voice)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    req_voice_d = req_voice_q;
    req_bank_d  = req_bank_q;
    req_mask_d  = req_mask_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    res_voice_d = res_voice_q;
    res_hit_d   = res_hit_q;
    out_voice_d = out_voice_q;
    out_hit_d   = out_hit_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          req_voice_d = voice_index_i;
          req_bank_d  = bank_i;
          req_mask_d  = track_mask_i;
          res_voice_d = voice_index_i;
          res_hit_d   = 1'b0;
          best_d      = PRIO_NONE;
          best_idx_d  = VOICE_FREE;
          cnt_d       = '0;
          unique case (mode_i)
            MODE_STEAL:   state_d = ST_SCAN;
            MODE_RELEASE: state_d = ST_REL;
            MODE_CHECK:   state_d = ST_CHK;
            default:      state_d = ST_FIN;
          endcase
        end
      end
      ST_SCAN: begin
        best_d     = fin_best;
        best_idx_d = fin_idx;
        if (scan_last) begin
          cnt_d = '0;
          if (fin_best == PRIO_NONE) begin
            res_voice_d = VOICE_FREE;
            state_d     = ST_FIN;
          end else begin
            res_voice_d = fin_idx;
            req_voice_d = fin_idx;
            state_d     = ST_REL;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_REL: begin
        if (trk_last) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_CHK: begin
        if (rd_voice == req_voice_q && req_mask_q[TRACK_W'(cnt_q)]) begin
          res_hit_d = 1'b1;
        end
        if (trk_last) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_voice_d = res_voice_q;
          out_hit_d   = res_hit_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      aux_en_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (psel && penable && pwrite && pready && paddr[2] == REG_AUX_EN) begin
        aux_en_q <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_voice_q <= req_voice_d;
    req_bank_q  <= req_bank_d;
    req_mask_q  <= req_mask_d;
    best_q      <= best_d;
    best_idx_q  <= best_idx_d;
    res_voice_q <= res_voice_d;
    res_hit_q   <= res_hit_d;
    out_voice_q <= out_voice_d;
    out_hit_q   <= out_hit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        prio_q[i] <= PRIO_NONE;
      end
    end else if (in_acc && mode_i == MODE_WR_PRIO &&
                 voice_index_i < VOICE_W'(NUM_VOICES)) begin
      prio_q[voice_index_i[VIDX_W-1:0]] <= priority_req_i;
    end
  end

  `VSA_ASSERT_IMP(a_scan_bound, state_q == ST_SCAN, cnt_q <= CNT_W'(NUM_VOICES - 1))
  `VSA_ASSERT_IMP(a_trk_bound, state_q == ST_REL || state_q == ST_CHK,
                  trk_last || cnt_q < CNT_W'(NUM_TRACKS - 1))
  `VSA_ASSERT_NXT(a_fin_wait, state_q == ST_FIN && out_valid_q && out_stall_i, state_q == ST_FIN)
  `VSA_ASSERT_IMP(a_out_from_fin, $rose(out_valid_q), $past(state_q) == ST_FIN)

endmodule

`default_nettype wire
